/* sv/fbrac_pkg.sv */
// Shared types, constants and helper functions for the five-byte rotate/add cipher.
// No dependencies; every other file in this block imports it.
`default_nettype none

package fbrac_pkg;

   localparam int NUM_ROUNDS = 5;
   localparam int BYTE_W     = 8;
   localparam int ROT_W      = 3;
   localparam int NIB_W      = 4;
   localparam int CHECK_W    = 5;

   // Operation codes carried on req_opcode.
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   // Per-round additive constant and the byte whose low bits set the rotation.
   localparam logic [BYTE_W-1:0] ROUND_CONST [NUM_ROUNDS] = '{
      8'h56, 8'h4F, 8'h4C, 8'h4B, 8'h53
   };
   localparam int ROT_SRC [NUM_ROUNDS] = '{4, 0, 3, 1, 2};

   // Marker bit that is always set in the check byte.
   localparam logic CHECK_MARK = 1'b1;

   typedef logic [NUM_ROUNDS-1:0][BYTE_W-1:0] block_type;

   // One pipeline beat: valid bit, mode, the block and the decrypt check nibble.
   typedef struct packed {
      logic              valid;
      logic              opcode;
      block_type         data;
      logic [NIB_W-1:0]  chk_nib;
   } stage_type;

   function automatic logic [BYTE_W-1:0] rot_right8(input logic [BYTE_W-1:0] v,
                                                    input logic [ROT_W-1:0]  r);
      logic [2*BYTE_W-1:0] w;
      w = {v, v} >> r;
      return w[BYTE_W-1:0];
   endfunction

   function automatic logic [BYTE_W-1:0] rot_left8(input logic [BYTE_W-1:0] v,
                                                   input logic [ROT_W-1:0]  r);
      logic [2*BYTE_W-1:0] w;
      w = {v, v} << r;
      return w[2*BYTE_W-1:BYTE_W];
   endfunction

   function automatic logic [BYTE_W-1:0] xor_all(input block_type b);
      logic [BYTE_W-1:0] x;
      x = '0;
      for (int i = 0; i < NUM_ROUNDS; i++) begin
         x = x ^ b[i];
      end
      return x;
   endfunction

   // Fold the XOR of all bytes into one nibble.
   function automatic logic [NIB_W-1:0] fold_nib(input block_type b);
      logic [BYTE_W-1:0] x;
      x = xor_all(b);
      return x[NIB_W-1:0] ^ x[BYTE_W-1:NIB_W];
   endfunction

endpackage

`default_nettype wire

/* sv/fbrac_round.sv */
// One pipeline stage of the cipher: encrypt round STAGE or decrypt round
// (NUM_ROUNDS-1-STAGE), selected per beat by the opcode. Depends on fbrac_pkg.
`default_nettype none

module fbrac_round
   import fbrac_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire stage_type stage_in,
   output stage_type      stage_out
);

   localparam int ENC_K = STAGE;
   localparam int DEC_K = NUM_ROUNDS - 1 - STAGE;

   stage_type         stage_ff;
   stage_type         stage_next_in;
   logic [BYTE_W-1:0] all_x;
   logic [BYTE_W-1:0] enc_byte;
   logic [BYTE_W-1:0] dec_diff;
   logic [BYTE_W-1:0] dec_byte;

   // Round arithmetic for both directions; the opcode picks the one that applies.
   always_comb begin
      all_x    = xor_all(stage_in.data);
      enc_byte = rot_right8(all_x, stage_in.data[ROT_SRC[ENC_K]][ROT_W-1:0])
                 + ROUND_CONST[ENC_K];
      dec_diff = stage_in.data[DEC_K] - ROUND_CONST[DEC_K];
      dec_byte = rot_left8(dec_diff, stage_in.data[ROT_SRC[DEC_K]][ROT_W-1:0])
                 ^ all_x ^ stage_in.data[DEC_K];

      stage_next_in = stage_in;
      if (stage_in.opcode == OP_DECRYPT) begin
         stage_next_in.data[DEC_K] = dec_byte;
      end else begin
         stage_next_in.data[ENC_K] = enc_byte;
      end
   end

   // Stage register; only the valid bit is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_next_in.valid;
      end
      stage_ff.opcode  <= stage_next_in.opcode;
      stage_ff.data    <= stage_next_in.data;
      stage_ff.chk_nib <= stage_next_in.chk_nib;
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

/* sv/fbrac_out.sv */
// Output stage: forms the check byte from the ciphertext and registers the
// result beat with its strobe. Depends on fbrac_pkg.
`default_nettype none

module fbrac_out
   import fbrac_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire stage_type          stage_in,
   output logic                    rsp_valid,
   output block_type               rsp_block,
   output logic [CHECK_W-1:0]      rsp_check
);

   logic                 rsp_valid_ff;
   block_type            rsp_block_ff;
   logic [CHECK_W-1:0]   rsp_check_ff;
   logic [NIB_W-1:0]     nib_in;

   // Encryption checks the result block; decryption carried its input nibble along.
   always_comb begin
      if (stage_in.opcode == OP_DECRYPT) begin
         nib_in = stage_in.chk_nib;
      end else begin
         nib_in = fold_nib(stage_in.data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stage_in.valid;
      end
      rsp_block_ff <= stage_in.data;
      rsp_check_ff <= {CHECK_MARK, nib_in};
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_block = rsp_block_ff;
   assign rsp_check = rsp_check_ff;

endmodule

`default_nettype wire

/* sv/five_byte_rotate_add_cipher_top.sv */
// Five-byte rotate/add cipher, one round per pipeline stage.
// A beat accepted at a clock edge is strobed on rsp_valid after passing six register stages
// (the round registers, then the result register; the first is loaded at the accept).
// Throughput: one beat per cycle; busy stays low and the receiver cannot stall.
// Reset clears only the stage valid bits and the result strobe; nothing else is kept.
// Depends on fbrac_pkg, fbrac_round and fbrac_out.
`default_nettype none

module five_byte_rotate_add_cipher_top
   import fbrac_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_opcode,
   input  wire logic [BYTE_W-1:0]  req_in_byte_0,
   input  wire logic [BYTE_W-1:0]  req_in_byte_1,
   input  wire logic [BYTE_W-1:0]  req_in_byte_2,
   input  wire logic [BYTE_W-1:0]  req_in_byte_3,
   input  wire logic [BYTE_W-1:0]  req_in_byte_4,
   output logic                    rsp_valid,
   output logic [BYTE_W-1:0]       rsp_out_byte_0,
   output logic [BYTE_W-1:0]       rsp_out_byte_1,
   output logic [BYTE_W-1:0]       rsp_out_byte_2,
   output logic [BYTE_W-1:0]       rsp_out_byte_3,
   output logic [BYTE_W-1:0]       rsp_out_byte_4,
   output logic [CHECK_W-1:0]      rsp_check_byte
);

   stage_type          stage [NUM_ROUNDS+1];
   stage_type          entry_beat;
   block_type          out_block;
   block_type          in_block;

   // The pipeline never holds input off.
   assign busy = 1'b0;

   // Build the entry beat; the decrypt check nibble comes from the input ciphertext.
   always_comb begin
      in_block             = {req_in_byte_4, req_in_byte_3, req_in_byte_2,
                              req_in_byte_1, req_in_byte_0};
      entry_beat.valid     = start & ~busy;
      entry_beat.opcode    = req_opcode;
      entry_beat.data      = in_block;
      entry_beat.chk_nib   = fold_nib(in_block);
   end

   assign stage[0] = entry_beat;

   // Round stages.
   for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
      fbrac_round #(
         .STAGE(g)
      ) u_round (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (stage[g]),
         .stage_out (stage[g+1])
      );
   end

   // Result register and check byte.
   fbrac_out u_out (
      .clock     (clock),
      .reset     (reset),
      .stage_in  (stage[NUM_ROUNDS]),
      .rsp_valid (rsp_valid),
      .rsp_block (out_block),
      .rsp_check (rsp_check_byte)
   );

   assign rsp_out_byte_0 = out_block[0];
   assign rsp_out_byte_1 = out_block[1];
   assign rsp_out_byte_2 = out_block[2];
   assign rsp_out_byte_3 = out_block[3];
   assign rsp_out_byte_4 = out_block[4];

endmodule

`default_nettype wire

/* tb/cipher_result_checker.sv */
`timescale 1ns / 1ps
// Result checker for the five-byte rotate/add cipher: watches both channels,
// predicts every block with its own model of the rounds and compares field by field.
// Depends on fbrac_pkg for widths and opcodes.

module cipher_result_checker
   import fbrac_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic                req_opcode,
   input  logic [BYTE_W-1:0]   req_in_byte_0,
   input  logic [BYTE_W-1:0]   req_in_byte_1,
   input  logic [BYTE_W-1:0]   req_in_byte_2,
   input  logic [BYTE_W-1:0]   req_in_byte_3,
   input  logic [BYTE_W-1:0]   req_in_byte_4,
   input  logic                rsp_valid,
   input  logic [BYTE_W-1:0]   rsp_out_byte_0,
   input  logic [BYTE_W-1:0]   rsp_out_byte_1,
   input  logic [BYTE_W-1:0]   rsp_out_byte_2,
   input  logic [BYTE_W-1:0]   rsp_out_byte_3,
   input  logic [BYTE_W-1:0]   rsp_out_byte_4,
   input  logic [CHECK_W-1:0]  rsp_check_byte,
   output int                  bad_blocks,
   output int                  blocks_in_flight
);

   // Round k adds ROUND_ADD[k] and rotates by the low bits of byte ROT_FROM[k].
   localparam logic [4:0][7:0] ROUND_ADD = {8'h53, 8'h4B, 8'h4C, 8'h4F, 8'h56};
   localparam logic [4:0][2:0] ROT_FROM  = {3'd2, 3'd1, 3'd3, 3'd0, 3'd4};
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [4:0][BYTE_W-1:0] bytes;
      logic [CHECK_W-1:0]     check;
   } cipher_block_type;

   cipher_block_type pending_blocks[$];
   int               error_tally = 0;

   // Encrypt or decrypt one block and derive the check byte from the ciphertext.
   function automatic cipher_block_type transform_block(input logic op,
                                                        input logic [4:0][BYTE_W-1:0] din);
      cipher_block_type  r;
      logic [4:0][7:0]   b;
      logic [7:0]        x;
      logic [7:0]        others;
      logic [7:0]        cipher_xor;
      logic [2:0]        amt;
      b = din;
      if (op == OP_ENCRYPT) begin
         for (int k = 0; k < 5; k++) begin
            x   = b[0] ^ b[1] ^ b[2] ^ b[3] ^ b[4];
            amt = b[ROT_FROM[k]][2:0];
            x   = (x >> amt) | (x << (4'd8 - amt));
            b[k] = x + ROUND_ADD[k];
         end
         cipher_xor = b[0] ^ b[1] ^ b[2] ^ b[3] ^ b[4];
      end else begin
         cipher_xor = b[0] ^ b[1] ^ b[2] ^ b[3] ^ b[4];
         for (int k = 4; k >= 0; k--) begin
            x   = b[k] - ROUND_ADD[k];
            amt = b[ROT_FROM[k]][2:0];
            x   = (x << amt) | (x >> (4'd8 - amt));
            others = 8'h00;
            for (int j = 0; j < 5; j++) begin
               if (j != k) others = others ^ b[j];
            end
            b[k] = x ^ others;
         end
      end
      r.bytes = b;
      r.check = {1'b1, cipher_xor[3:0] ^ cipher_xor[7:4]};
      return r;
   endfunction

   // Compare the result beat first, then record a newly accepted block.
   always @(posedge clock) begin
      cipher_block_type seen;
      cipher_block_type want;
      if (!reset) begin
         if (rsp_valid !== 1'b0) begin
            seen.bytes = {rsp_out_byte_4, rsp_out_byte_3, rsp_out_byte_2,
                          rsp_out_byte_1, rsp_out_byte_0};
            seen.check = rsp_check_byte;
            if (pending_blocks.size() == 0) begin
               error_tally++;
               if (error_tally <= REPORT_LIMIT)
                  $display("%0t: result beat with no block outstanding: %h %h", $realtime,
                           seen.bytes, seen.check);
            end else begin
               want = pending_blocks.pop_front();
               if (rsp_valid !== 1'b1 || seen.bytes !== want.bytes
                   || seen.check !== want.check) begin
                  error_tally++;
                  if (error_tally <= REPORT_LIMIT)
                     $display("%0t: block mismatch: bytes[4:0] exp %h got %h, check exp %h got %h",
                              $realtime, want.bytes, seen.bytes, want.check, seen.check);
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            pending_blocks.push_back(transform_block(req_opcode,
               {req_in_byte_4, req_in_byte_3, req_in_byte_2, req_in_byte_1, req_in_byte_0}));
      end
      bad_blocks       <= error_tally;
      blocks_in_flight <= pending_blocks.size();
   end

endmodule

/* tb/five_byte_rotate_add_cipher_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the five-byte rotate/add cipher: clock, reset, directed and
// random block stimulus in bursts, and the verdict. Depends on fbrac_pkg,
// the cipher RTL and cipher_result_checker.

module five_byte_rotate_add_cipher_top_tb;
   import fbrac_pkg::*;

   localparam int RANDOM_BLOCKS = 450;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_opcode = OP_ENCRYPT;
   logic [BYTE_W-1:0]  req_in_byte_0 = '0;
   logic [BYTE_W-1:0]  req_in_byte_1 = '0;
   logic [BYTE_W-1:0]  req_in_byte_2 = '0;
   logic [BYTE_W-1:0]  req_in_byte_3 = '0;
   logic [BYTE_W-1:0]  req_in_byte_4 = '0;
   logic               rsp_valid;
   logic [BYTE_W-1:0]  rsp_out_byte_0;
   logic [BYTE_W-1:0]  rsp_out_byte_1;
   logic [BYTE_W-1:0]  rsp_out_byte_2;
   logic [BYTE_W-1:0]  rsp_out_byte_3;
   logic [BYTE_W-1:0]  rsp_out_byte_4;
   logic [CHECK_W-1:0] rsp_check_byte;
   int                 bad_blocks;
   int                 blocks_in_flight;

   always #4 clock = ~clock;

   five_byte_rotate_add_cipher_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_in_byte_0  (req_in_byte_0),
      .req_in_byte_1  (req_in_byte_1),
      .req_in_byte_2  (req_in_byte_2),
      .req_in_byte_3  (req_in_byte_3),
      .req_in_byte_4  (req_in_byte_4),
      .rsp_valid      (rsp_valid),
      .rsp_out_byte_0 (rsp_out_byte_0),
      .rsp_out_byte_1 (rsp_out_byte_1),
      .rsp_out_byte_2 (rsp_out_byte_2),
      .rsp_out_byte_3 (rsp_out_byte_3),
      .rsp_out_byte_4 (rsp_out_byte_4),
      .rsp_check_byte (rsp_check_byte)
   );

   cipher_result_checker u_result_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_in_byte_0    (req_in_byte_0),
      .req_in_byte_1    (req_in_byte_1),
      .req_in_byte_2    (req_in_byte_2),
      .req_in_byte_3    (req_in_byte_3),
      .req_in_byte_4    (req_in_byte_4),
      .rsp_valid        (rsp_valid),
      .rsp_out_byte_0   (rsp_out_byte_0),
      .rsp_out_byte_1   (rsp_out_byte_1),
      .rsp_out_byte_2   (rsp_out_byte_2),
      .rsp_out_byte_3   (rsp_out_byte_3),
      .rsp_out_byte_4   (rsp_out_byte_4),
      .rsp_check_byte   (rsp_check_byte),
      .bad_blocks       (bad_blocks),
      .blocks_in_flight (blocks_in_flight)
   );

   // Present one block and hold it until the block takes the beat.
   task automatic send_block(input logic op, input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3,
                             input logic [7:0] b4);
      start         <= 1'b1;
      req_opcode    <= op;
      req_in_byte_0 <= b0;
      req_in_byte_1 <= b1;
      req_in_byte_2 <= b2;
      req_in_byte_3 <= b3;
      req_in_byte_4 <= b4;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Drop start and let the given number of cycles pass.
   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Wait until every accepted block has produced its result.
   task automatic drain_results;
      start <= 1'b0;
      @(posedge clock);
      while (blocks_in_flight != 0) @(posedge clock);
   endtask

   // Mostly uniform bytes, with extremes and zero rotation amounts mixed in.
   function automatic logic [7:0] pick_byte;
      logic [7:0] v;
      case ($urandom_range(0, 9))
         0:       v = 8'h00;
         1:       v = 8'hFF;
         2:       v = {5'($urandom_range(0, 31)), 3'b000};
         default: v = 8'($urandom_range(0, 255));
      endcase
      return v;
   endfunction

   initial begin
      int burst_left;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed blocks: extremes, both modes, zero rotation sources, single bits.
      send_block(OP_ENCRYPT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_block(OP_DECRYPT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_block(OP_ENCRYPT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_block(OP_DECRYPT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_block(OP_ENCRYPT, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA);
      send_block(OP_DECRYPT, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55);
      send_block(OP_ENCRYPT, 8'h08, 8'h10, 8'h18, 8'h20, 8'hF8);
      send_block(OP_DECRYPT, 8'h56, 8'h4F, 8'h4C, 8'h4B, 8'h53);
      send_block(OP_ENCRYPT, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07);
      send_block(OP_DECRYPT, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07);
      hold_off(3);
      for (int i = 0; i < 8; i++) begin
         send_block(i[0] ? OP_DECRYPT : OP_ENCRYPT, 8'(1 << i), 8'(1 << ((i + 1) % 8)),
                    8'(1 << ((i + 2) % 8)), 8'(1 << ((i + 3) % 8)), 8'(1 << ((i + 4) % 8)));
      end
      send_block(OP_ENCRYPT, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00);
      send_block(OP_DECRYPT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80);
      drain_results();

      // Random blocks in bursts, with one full drain halfway through.
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < RANDOM_BLOCKS; n++) begin
         if (n == RANDOM_BLOCKS / 2) drain_results();
         send_block($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT,
                    pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte());
         burst_left--;
         if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 7));
            burst_left = $urandom_range(1, 24);
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (bad_blocks == 0 && blocks_in_flight == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog for a hung handshake or a missing result.
   initial begin
      #400000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* files.f */
sv/fbrac_pkg.sv
sv/fbrac_round.sv
sv/fbrac_out.sv
sv/five_byte_rotate_add_cipher_top.sv
tb/cipher_result_checker.sv
tb/five_byte_rotate_add_cipher_top_tb.sv
